// ===== hw/rtl/qap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared constants, types and register codes of the quantized average pool
package qap_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int MAX_FILTER  = 16;

    localparam int SAMPLE_W    = 8;
    localparam int COORD_W     = 12;
    localparam int TAP_W       = 4;
    localparam int STRIDE_W    = 5;
    localparam int PAD_W       = 4;
    localparam int FILT_W      = 5;
    localparam int DIM_W       = 13;
    localparam int CLAMP_W     = 16;
    localparam int AVG_W       = 8;
    localparam int SUM_W       = 16;

    localparam int PROD_W      = COORD_W + STRIDE_W;
    localparam int ORG_W       = PROD_W + 2;
    localparam int SPAN_W      = $clog2(MAX_FILTER) + 1;
    localparam int COUNT_W     = 2 * SPAN_W - 1;
    localparam int NUM_W       = SUM_W + 1;
    localparam int STEP_W      = $clog2(NUM_W);

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STRIDE        = 3'd0,
        REG_PAD_WIDTH     = 3'd1,
        REG_PAD_HEIGHT    = 3'd2,
        REG_FILTER_WIDTH  = 3'd3,
        REG_FILTER_HEIGHT = 3'd4,
        REG_IMAGE_WIDTH   = 3'd5,
        REG_IMAGE_HEIGHT  = 3'd6,
        REG_CLAMP_BOUNDS  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [STRIDE_W-1:0] stride;
        logic [PAD_W-1:0]    pad_left;
        logic [PAD_W-1:0]    pad_top;
        logic [FILT_W-1:0]   win_width;
        logic [FILT_W-1:0]   win_height;
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic [CLAMP_W-1:0]  clamp_bounds;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        stride:        STRIDE_W'(1),
        pad_left:      PAD_W'(0),
        pad_top:       PAD_W'(0),
        win_width:     FILT_W'(1),
        win_height:    FILT_W'(1),
        image_width:   DIM_W'(MAX_DIM),
        image_height:  DIM_W'(MAX_DIM),
        clamp_bounds:  CLAMP_W'(16'hFF00)
    };

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } win_t;

endpackage
`default_nettype wire

// ===== hw/rtl/qap_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// tap intake: window origin, in-image test, running sum and window tap count
module qap_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire qap_pkg::cfg_t                cfg,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [qap_pkg::SAMPLE_W-1:0] s_sample,
    input  wire logic [qap_pkg::COORD_W-1:0]  s_out_x,
    input  wire logic [qap_pkg::COORD_W-1:0]  s_out_y,
    input  wire logic [qap_pkg::TAP_W-1:0]    s_tap_x,
    input  wire logic [qap_pkg::TAP_W-1:0]    s_tap_y,
    input  wire logic                         s_last_tap,
    input  wire logic                         q_full,
    output logic                              q_push,
    output qap_pkg::win_t                     q_data
);

    function automatic logic [qap_pkg::SPAN_W-1:0] span_count(
        input logic signed [qap_pkg::ORG_W-1:0] origin,
        input logic [qap_pkg::FILT_W-1:0]       filt,
        input logic [qap_pkg::DIM_W-1:0]        extent
    );
        logic signed [qap_pkg::ORG_W-1:0] start;
        logic signed [qap_pkg::ORG_W-1:0] stop;
        logic signed [qap_pkg::ORG_W-1:0] diff;
        start = origin[qap_pkg::ORG_W-1] ? -origin : '0;
        stop  = $signed(qap_pkg::ORG_W'(extent)) - origin;
        if ($signed(qap_pkg::ORG_W'(filt)) < stop) begin
            stop = $signed(qap_pkg::ORG_W'(filt));
        end
        diff = stop - start;
        return (stop > start) ? diff[qap_pkg::SPAN_W-1:0] : '0;
    endfunction

    logic                                adv;
    logic [qap_pkg::PROD_W-1:0]          prod_x;
    logic [qap_pkg::PROD_W-1:0]          prod_y;
    logic signed [qap_pkg::ORG_W-1:0]    org_x;
    logic signed [qap_pkg::ORG_W-1:0]    org_y;

    logic                                a_valid_reg;
    logic                                a_valid_next;
    logic [qap_pkg::SAMPLE_W-1:0]        a_sample_reg;
    logic signed [qap_pkg::ORG_W-1:0]    a_org_x_reg;
    logic signed [qap_pkg::ORG_W-1:0]    a_org_y_reg;
    logic [qap_pkg::TAP_W-1:0]           a_tap_x_reg;
    logic [qap_pkg::TAP_W-1:0]           a_tap_y_reg;
    logic                                a_last_reg;

    logic [qap_pkg::FILT_W-1:0]          fw;
    logic [qap_pkg::FILT_W-1:0]          fh;
    logic [qap_pkg::DIM_W-1:0]           iw;
    logic [qap_pkg::DIM_W-1:0]           ih;
    logic signed [qap_pkg::ORG_W-1:0]    px;
    logic signed [qap_pkg::ORG_W-1:0]    py;
    logic                                in_img;
    logic [qap_pkg::SUM_W-1:0]           sum_acc;

    logic [qap_pkg::SUM_W-1:0]           sum_reg;
    logic [qap_pkg::SUM_W-1:0]           sum_next;
    logic                                c_valid_reg;
    logic                                c_valid_next;
    logic [qap_pkg::SUM_W-1:0]           c_sum_reg;
    logic [qap_pkg::SPAN_W-1:0]          c_sx_reg;
    logic [qap_pkg::SPAN_W-1:0]          c_sy_reg;
    logic [qap_pkg::COUNT_W-1:0]         c_prod;

    // whole front moves together; it only waits on a full queue
    assign adv     = !c_valid_reg || !q_full;
    assign s_ready = adv;
    assign q_push  = c_valid_reg && adv;

    // window origin per axis
    assign prod_x = qap_pkg::PROD_W'(s_out_x) * qap_pkg::PROD_W'(cfg.stride);
    assign prod_y = qap_pkg::PROD_W'(s_out_y) * qap_pkg::PROD_W'(cfg.stride);
    assign org_x  = $signed(qap_pkg::ORG_W'(prod_x)) - $signed(qap_pkg::ORG_W'(cfg.pad_left));
    assign org_y  = $signed(qap_pkg::ORG_W'(prod_y)) - $signed(qap_pkg::ORG_W'(cfg.pad_top));

    // saturated geometry
    assign fw = (cfg.win_width > qap_pkg::FILT_W'(qap_pkg::MAX_FILTER))
              ? qap_pkg::FILT_W'(qap_pkg::MAX_FILTER) : cfg.win_width;
    assign fh = (cfg.win_height > qap_pkg::FILT_W'(qap_pkg::MAX_FILTER))
              ? qap_pkg::FILT_W'(qap_pkg::MAX_FILTER) : cfg.win_height;
    assign iw = (cfg.image_width > qap_pkg::DIM_W'(qap_pkg::MAX_DIM))
              ? qap_pkg::DIM_W'(qap_pkg::MAX_DIM) : cfg.image_width;
    assign ih = (cfg.image_height > qap_pkg::DIM_W'(qap_pkg::MAX_DIM))
              ? qap_pkg::DIM_W'(qap_pkg::MAX_DIM) : cfg.image_height;

    assign px = a_org_x_reg + $signed(qap_pkg::ORG_W'(a_tap_x_reg));
    assign py = a_org_y_reg + $signed(qap_pkg::ORG_W'(a_tap_y_reg));

    assign in_img = (qap_pkg::FILT_W'(a_tap_x_reg) < fw)
                 && (qap_pkg::FILT_W'(a_tap_y_reg) < fh)
                 && !px[qap_pkg::ORG_W-1] && (px < $signed(qap_pkg::ORG_W'(iw)))
                 && !py[qap_pkg::ORG_W-1] && (py < $signed(qap_pkg::ORG_W'(ih)));

    assign sum_acc = sum_reg + (in_img ? qap_pkg::SUM_W'(a_sample_reg) : '0);

    always_comb begin
        a_valid_next = adv ? s_valid : a_valid_reg;
        sum_next     = sum_reg;
        c_valid_next = c_valid_reg;
        if (adv) begin
            c_valid_next = 1'b0;
            if (a_valid_reg) begin
                sum_next = sum_acc;
                if (a_last_reg) begin
                    sum_next     = '0;
                    c_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            sum_reg     <= '0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            sum_reg     <= sum_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_sample_reg <= s_sample;
            a_org_x_reg  <= org_x;
            a_org_y_reg  <= org_y;
            a_tap_x_reg  <= s_tap_x;
            a_tap_y_reg  <= s_tap_y;
            a_last_reg   <= s_last_tap;
        end
        if (adv && a_valid_reg && a_last_reg) begin
            c_sum_reg <= sum_acc;
            c_sx_reg  <= span_count(a_org_x_reg, fw, iw);
            c_sy_reg  <= span_count(a_org_y_reg, fh, ih);
        end
    end

    assign c_prod       = qap_pkg::COUNT_W'(c_sx_reg) * qap_pkg::COUNT_W'(c_sy_reg);
    assign q_data.sum   = c_sum_reg;
    assign q_data.count = c_prod;

endmodule
`default_nettype wire

// ===== hw/rtl/qap_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// short window queue between the tap front and the divide back
module qap_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire qap_pkg::win_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output qap_pkg::win_t      pop_data
);

    qap_pkg::win_t              mem_reg [qap_pkg::QUEUE_DEPTH];
    logic [qap_pkg::PTR_W-1:0]  wr_ptr_reg;
    logic [qap_pkg::PTR_W-1:0]  wr_ptr_next;
    logic [qap_pkg::PTR_W-1:0]  rd_ptr_reg;
    logic [qap_pkg::PTR_W-1:0]  rd_ptr_next;
    logic [qap_pkg::LVL_W-1:0]  level_reg;
    logic [qap_pkg::LVL_W-1:0]  level_next;

    assign full     = level_reg == qap_pkg::LVL_W'(qap_pkg::QUEUE_DEPTH);
    assign empty    = level_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == qap_pkg::PTR_W'(qap_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + qap_pkg::PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == qap_pkg::PTR_W'(qap_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + qap_pkg::PTR_W'(1);
        end
        if (push && !pop) begin
            level_next = level_reg + qap_pkg::LVL_W'(1);
        end else if (pop && !push) begin
            level_next = level_reg - qap_pkg::LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("window queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("window queue read while empty");

endmodule
`default_nettype wire

// ===== hw/rtl/qap_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// window divide, saturate, clamp and result register
module qap_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_empty,
    output logic                              q_pop,
    input  wire qap_pkg::win_t                q_data,
    input  wire logic [qap_pkg::CLAMP_W-1:0]  clamp_bounds,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [qap_pkg::AVG_W-1:0]         m_average,
    output logic [qap_pkg::COUNT_W-1:0]       m_tap_count
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } back_state_t;

    back_state_t                  state_reg;
    back_state_t                  state_next;
    logic [qap_pkg::NUM_W-1:0]    num_reg;
    logic [qap_pkg::NUM_W-1:0]    num_next;
    logic [qap_pkg::COUNT_W-1:0]  rem_reg;
    logic [qap_pkg::COUNT_W-1:0]  rem_next;
    logic [qap_pkg::COUNT_W-1:0]  den_reg;
    logic [qap_pkg::COUNT_W-1:0]  den_next;
    logic [qap_pkg::STEP_W-1:0]   step_reg;
    logic [qap_pkg::STEP_W-1:0]   step_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [qap_pkg::AVG_W-1:0]    out_avg_reg;
    logic [qap_pkg::COUNT_W-1:0]  out_count_reg;

    logic [qap_pkg::COUNT_W:0]    trial;
    logic [qap_pkg::COUNT_W:0]    trial_diff;
    logic                         take;
    logic [qap_pkg::AVG_W-1:0]    sat;
    logic [qap_pkg::AVG_W-1:0]    lo;
    logic [qap_pkg::AVG_W-1:0]    hi;
    logic [qap_pkg::AVG_W-1:0]    above_lo;
    logic [qap_pkg::AVG_W-1:0]    result;
    logic                         out_free;
    logic                         out_load;

    // one restoring quotient bit per cycle
    assign trial      = {rem_reg, num_reg[qap_pkg::NUM_W-1]};
    assign take       = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    // empty window divides to zero
    assign sat = (den_reg == '0) ? '0
               : (num_reg > qap_pkg::NUM_W'({qap_pkg::AVG_W{1'b1}})) ? '1
               : num_reg[qap_pkg::AVG_W-1:0];
    assign lo       = clamp_bounds[qap_pkg::AVG_W-1:0];
    assign hi       = clamp_bounds[qap_pkg::CLAMP_W-1:qap_pkg::AVG_W];
    assign above_lo = (sat < lo) ? lo : sat;
    assign result   = (above_lo > hi) ? hi : above_lo;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        step_next  = step_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    num_next   = qap_pkg::NUM_W'(q_data.sum)
                               + qap_pkg::NUM_W'(q_data.count >> 1);
                    den_next   = q_data.count;
                    rem_next   = '0;
                    step_next  = qap_pkg::STEP_W'(qap_pkg::NUM_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                num_next  = {num_reg[qap_pkg::NUM_W-2:0], take};
                rem_next  = take ? trial_diff[qap_pkg::COUNT_W-1:0]
                                 : trial[qap_pkg::COUNT_W-1:0];
                step_next = step_reg - qap_pkg::STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        step_reg <= step_next;
        if (out_load) begin
            out_avg_reg   <= result;
            out_count_reg <= den_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_average   = out_avg_reg;
    assign m_tap_count = out_count_reg;

    a_hold_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && out_free) |=> out_valid_reg)
        else $error("finished window did not reach the result register");

    a_pop_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == ST_DIV
                   && step_reg == qap_pkg::STEP_W'(qap_pkg::NUM_W - 1)))
        else $error("window taken without starting a full divide");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
            out_count_reg <= qap_pkg::COUNT_W'(qap_pkg::MAX_FILTER * qap_pkg::MAX_FILTER))
        else $error("tap count beyond the largest window");

endmodule
`default_nettype wire

// ===== hw/rtl/quantized_average_pool_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Average pool over one 8-bit channel, fed one window tap per item. The front
// end takes a tap every cycle except while it waits on a full queue, and keeps
// the running window sum; on the last tap of a window the sum and the in-image
// tap count go into a two-entry queue. The back end turns each window into a
// result with a 17-step restoring divider: it loads a window from the queue,
// runs the steps and moves the result into the result register before the
// next. Long windows stream at one tap per cycle; short ones are paced by the
// divider once the queue is full. Configuration registers sit in this module.
module quantized_average_pool_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [qap_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [qap_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [qap_pkg::SAMPLE_W-1:0]     s_sample,
    input  wire logic [qap_pkg::COORD_W-1:0]      s_out_x,
    input  wire logic [qap_pkg::COORD_W-1:0]      s_out_y,
    input  wire logic [qap_pkg::TAP_W-1:0]        s_tap_x,
    input  wire logic [qap_pkg::TAP_W-1:0]        s_tap_y,
    input  wire logic                             s_last_tap,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [qap_pkg::AVG_W-1:0]             m_average,
    output logic [qap_pkg::COUNT_W-1:0]           m_tap_count
);

    qap_pkg::cfg_t  cfg_reg;
    qap_pkg::cfg_t  cfg_next;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    qap_pkg::win_t  q_wr_data;
    qap_pkg::win_t  q_rd_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (qap_pkg::cfg_idx_t'(cfg_addr))
                qap_pkg::REG_STRIDE:
                    cfg_next.stride = cfg_wdata[qap_pkg::STRIDE_W-1:0];
                qap_pkg::REG_PAD_WIDTH:
                    cfg_next.pad_left = cfg_wdata[qap_pkg::PAD_W-1:0];
                qap_pkg::REG_PAD_HEIGHT:
                    cfg_next.pad_top = cfg_wdata[qap_pkg::PAD_W-1:0];
                qap_pkg::REG_FILTER_WIDTH:
                    cfg_next.win_width = cfg_wdata[qap_pkg::FILT_W-1:0];
                qap_pkg::REG_FILTER_HEIGHT:
                    cfg_next.win_height = cfg_wdata[qap_pkg::FILT_W-1:0];
                qap_pkg::REG_IMAGE_WIDTH:
                    cfg_next.image_width = cfg_wdata[qap_pkg::DIM_W-1:0];
                qap_pkg::REG_IMAGE_HEIGHT:
                    cfg_next.image_height = cfg_wdata[qap_pkg::DIM_W-1:0];
                qap_pkg::REG_CLAMP_BOUNDS:
                    cfg_next.clamp_bounds = cfg_wdata[qap_pkg::CLAMP_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= qap_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    qap_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_out_x    (s_out_x),
        .s_out_y    (s_out_y),
        .s_tap_x    (s_tap_x),
        .s_tap_y    (s_tap_y),
        .s_last_tap (s_last_tap),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    qap_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_rd_data)
    );

    qap_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_data       (q_rd_data),
        .clamp_bounds (cfg_reg.clamp_bounds),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_average    (m_average),
        .m_tap_count  (m_tap_count)
    );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for quantized_average_pool_core: directed and random taps against a predictor
module tb_top;

    localparam int TAP_TARGET   = 370;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_PCT     = 35;

    typedef struct {
        logic [qap_pkg::SAMPLE_W-1:0] sample;
        logic [qap_pkg::COORD_W-1:0]  ox;
        logic [qap_pkg::COORD_W-1:0]  oy;
        logic [qap_pkg::TAP_W-1:0]    tx;
        logic [qap_pkg::TAP_W-1:0]    ty;
        logic                         last;
    } pool_tap_t;

    typedef struct {
        logic [qap_pkg::AVG_W-1:0]   avg;
        logic [qap_pkg::COUNT_W-1:0] count;
    } pool_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [qap_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [qap_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [qap_pkg::SAMPLE_W-1:0]   s_sample = '0;
    logic [qap_pkg::COORD_W-1:0]    s_out_x = '0;
    logic [qap_pkg::COORD_W-1:0]    s_out_y = '0;
    logic [qap_pkg::TAP_W-1:0]      s_tap_x = '0;
    logic [qap_pkg::TAP_W-1:0]      s_tap_y = '0;
    logic                           s_last_tap = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [qap_pkg::AVG_W-1:0]      m_average;
    logic [qap_pkg::COUNT_W-1:0]    m_tap_count;

    pool_tap_t                 tap_q[$];
    pool_result_t              window_avgs_q[$];
    pool_tap_t                 cur_tap;
    qap_pkg::cfg_t             geom;
    logic [qap_pkg::SUM_W-1:0] win_sum = '0;
    int                        errors = 0;
    int                        cycles = 0;
    int                        taps_queued = 0;
    bit                        calm = 1'b0;

    quantized_average_pool_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_out_x     (s_out_x),
        .s_out_y     (s_out_y),
        .s_tap_x     (s_tap_x),
        .s_tap_y     (s_tap_y),
        .s_last_tap  (s_last_tap),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_average   (m_average),
        .m_tap_count (m_tap_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int span_in_image(int origin, int filt, int extent);
        int first;
        int stop;
        first = origin < 0 ? -origin : 0;
        stop = extent - origin;
        if (filt < stop) begin
            stop = filt;
        end
        return stop > first ? stop - first : 0;
    endfunction

    // running sum per tap, rounded and clamped average on the last tap
    function automatic void accumulate_tap(pool_tap_t t);
        int fw;
        int fh;
        int iw;
        int ih;
        int xo;
        int yo;
        int px;
        int py;
        int cnt;
        int q;
        pool_result_t r;
        fw = int'(geom.win_width) > qap_pkg::MAX_FILTER
           ? qap_pkg::MAX_FILTER : int'(geom.win_width);
        fh = int'(geom.win_height) > qap_pkg::MAX_FILTER
           ? qap_pkg::MAX_FILTER : int'(geom.win_height);
        iw = int'(geom.image_width) > qap_pkg::MAX_DIM
           ? qap_pkg::MAX_DIM : int'(geom.image_width);
        ih = int'(geom.image_height) > qap_pkg::MAX_DIM
           ? qap_pkg::MAX_DIM : int'(geom.image_height);
        xo = int'(t.ox) * int'(geom.stride) - int'(geom.pad_left);
        yo = int'(t.oy) * int'(geom.stride) - int'(geom.pad_top);
        px = xo + int'(t.tx);
        py = yo + int'(t.ty);
        if (int'(t.tx) < fw && int'(t.ty) < fh
            && px >= 0 && px < iw && py >= 0 && py < ih) begin
            win_sum = win_sum + qap_pkg::SUM_W'(t.sample);
        end
        if (!t.last) begin
            return;
        end
        cnt = span_in_image(xo, fw, iw) * span_in_image(yo, fh, ih);
        q = cnt != 0 ? (int'(win_sum) + cnt / 2) / cnt : 0;
        if (q > 255) begin
            q = 255;
        end
        if (q < int'(geom.clamp_bounds[7:0])) begin
            q = int'(geom.clamp_bounds[7:0]);
        end
        if (q > int'(geom.clamp_bounds[15:8])) begin
            q = int'(geom.clamp_bounds[15:8]);
        end
        r.avg = qap_pkg::AVG_W'(q);
        r.count = qap_pkg::COUNT_W'(cnt);
        window_avgs_q.push_back(r);
        win_sum = '0;
    endfunction

    function automatic void push_tap(int sample, int ox, int oy, int tx, int ty, bit last);
        pool_tap_t t;
        t.sample = qap_pkg::SAMPLE_W'(sample);
        t.ox = qap_pkg::COORD_W'(ox);
        t.oy = qap_pkg::COORD_W'(oy);
        t.tx = qap_pkg::TAP_W'(tx);
        t.ty = qap_pkg::TAP_W'(ty);
        t.last = last;
        tap_q.push_back(t);
        taps_queued++;
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(9))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic void queue_window(int ox, int oy, int nx, int ny);
        if (nx == 0 || ny == 0) begin
            push_tap(rand_sample(), ox, oy, 0, 0, 1'b1);
            return;
        end
        for (int ty = 0; ty < ny; ty++) begin
            for (int tx = 0; tx < nx; tx++) begin
                push_tap(rand_sample(), ox, oy, tx, ty, tx == nx - 1 && ty == ny - 1);
            end
        end
    endfunction

    // output positions mostly near the image so windows straddle the edges
    function automatic int pick_origin(int extent, int str);
        int ext;
        int hi;
        ext = extent > qap_pkg::MAX_DIM ? qap_pkg::MAX_DIM : extent;
        if (str == 0 || $urandom_range(9) == 0) begin
            return $urandom_range(4095);
        end
        hi = ext / str + 2;
        if (hi > 4095) begin
            hi = 4095;
        end
        return $urandom_range(hi);
    endfunction

    function automatic void queue_random_window();
        int nx;
        int ny;
        nx = int'(geom.win_width) > qap_pkg::MAX_FILTER
           ? qap_pkg::MAX_FILTER : int'(geom.win_width);
        ny = int'(geom.win_height) > qap_pkg::MAX_FILTER
           ? qap_pkg::MAX_FILTER : int'(geom.win_height);
        if ($urandom_range(7) == 0 && nx < 16) begin
            nx++;
        end
        if ($urandom_range(7) == 0 && ny < 16) begin
            ny++;
        end
        queue_window(pick_origin(int'(geom.image_width), int'(geom.stride)),
                     pick_origin(int'(geom.image_height), int'(geom.stride)), nx, ny);
    endfunction

    task automatic write_reg(qap_pkg::cfg_idx_t idx, logic [qap_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            qap_pkg::REG_STRIDE:        geom.stride = val[qap_pkg::STRIDE_W-1:0];
            qap_pkg::REG_PAD_WIDTH:     geom.pad_left = val[qap_pkg::PAD_W-1:0];
            qap_pkg::REG_PAD_HEIGHT:    geom.pad_top = val[qap_pkg::PAD_W-1:0];
            qap_pkg::REG_FILTER_WIDTH:  geom.win_width = val[qap_pkg::FILT_W-1:0];
            qap_pkg::REG_FILTER_HEIGHT: geom.win_height = val[qap_pkg::FILT_W-1:0];
            qap_pkg::REG_IMAGE_WIDTH:   geom.image_width = val[qap_pkg::DIM_W-1:0];
            qap_pkg::REG_IMAGE_HEIGHT:  geom.image_height = val[qap_pkg::DIM_W-1:0];
            qap_pkg::REG_CLAMP_BOUNDS:  geom.clamp_bounds = val[qap_pkg::CLAMP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_geometry(int st, int pw, int ph, int fw, int fh, int iw, int ih,
                                  int cb);
        write_reg(qap_pkg::REG_STRIDE, qap_pkg::CFG_DATA_W'(st));
        write_reg(qap_pkg::REG_PAD_WIDTH, qap_pkg::CFG_DATA_W'(pw));
        write_reg(qap_pkg::REG_PAD_HEIGHT, qap_pkg::CFG_DATA_W'(ph));
        write_reg(qap_pkg::REG_FILTER_WIDTH, qap_pkg::CFG_DATA_W'(fw));
        write_reg(qap_pkg::REG_FILTER_HEIGHT, qap_pkg::CFG_DATA_W'(fh));
        write_reg(qap_pkg::REG_IMAGE_WIDTH, qap_pkg::CFG_DATA_W'(iw));
        write_reg(qap_pkg::REG_IMAGE_HEIGHT, qap_pkg::CFG_DATA_W'(ih));
        write_reg(qap_pkg::REG_CLAMP_BOUNDS, qap_pkg::CFG_DATA_W'(cb));
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic randomize_geometry();
        int st;
        int pw;
        int ph;
        int fw;
        int fh;
        int dims[2];
        int cb;
        case ($urandom_range(9))
            0: st = 0;
            1: st = 31;
            2: st = 16;
            default: st = $urandom_range(1, 4);
        endcase
        pw = $urandom_range(7) == 0 ? $urandom_range(15) : $urandom_range(3);
        ph = $urandom_range(7) == 0 ? 15 : $urandom_range(3);
        case ($urandom_range(11))
            0: fw = 0;
            1: fw = 16;
            2: fw = $urandom_range(17, 31);
            default: fw = $urandom_range(1, 4);
        endcase
        case ($urandom_range(11))
            0: fh = 0;
            1: fh = 16;
            2: fh = $urandom_range(17, 31);
            default: fh = $urandom_range(1, 4);
        endcase
        if (fw >= 9 && fh >= 9) begin
            fh = $urandom_range(1, 3);
        end
        for (int d = 0; d < 2; d++) begin
            case ($urandom_range(11))
                0: dims[d] = 0;
                1: dims[d] = 4096;
                2: dims[d] = $urandom_range(4097, 8191);
                3: dims[d] = $urandom_range(8191);
                default: dims[d] = $urandom_range(1, 24);
            endcase
        end
        case ($urandom_range(5))
            0: cb = $urandom_range(65535);
            1: cb = 16'h00FF;
            2: cb = $urandom_range(128, 255) * 256 + $urandom_range(127);
            default: cb = 16'hFF00;
        endcase
        write_geometry(st, pw, ph, fw, fh, dims[0], dims[1], cb);
    endtask

    // every queued item sent and every average seen, then the divider tail
    task automatic drain();
        while (tap_q.size() != 0 || s_valid || window_avgs_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive_taps
        bit busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                accumulate_tap(cur_tap);
                busy = 1'b0;
            end
            if (!busy && tap_q.size() != 0
                && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                cur_tap = tap_q.pop_front();
                s_sample <= cur_tap.sample;
                s_out_x <= cur_tap.ox;
                s_out_y <= cur_tap.oy;
                s_tap_x <= cur_tap.tx;
                s_tap_y <= cur_tap.ty;
                s_last_tap <= cur_tap.last;
                busy = 1'b1;
            end
            s_valid <= busy;
        end
    end

    always @(posedge aclk) begin : check_averages
        pool_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (window_avgs_q.size() == 0) begin
                    $display("%0t: unexpected item, average %0d tap_count %0d",
                             $time, m_average, m_tap_count);
                    errors++;
                end else begin
                    want = window_avgs_q.pop_front();
                    if (m_average !== want.avg) begin
                        $display("%0t: average expected %0d actual %0d",
                                 $time, want.avg, m_average);
                        errors++;
                    end
                    if (m_tap_count !== want.count) begin
                        $display("%0t: tap_count expected %0d actual %0d",
                                 $time, want.count, m_tap_count);
                        errors++;
                    end
                end
            end
            m_ready <= calm || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("quantized_average_pool_core test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_no;
        int first;
        int phase_len;
        int random_taps;
        geom.stride = 1;
        geom.pad_left = 0;
        geom.pad_top = 0;
        geom.win_width = 1;
        geom.win_height = 1;
        geom.image_width = 4096;
        geom.image_height = 4096;
        geom.clamp_bounds = 16'hFF00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // settings out of reset: field extremes, tap outside the filter, two-tap window
        push_tap(0, 0, 0, 0, 0, 1'b1);
        push_tap(255, 4095, 4095, 0, 0, 1'b1);
        push_tap(200, 5, 5, 15, 15, 1'b1);
        push_tap(77, 3, 7, 0, 0, 1'b0);
        push_tap(9, 3, 7, 1, 0, 1'b1);
        drain();

        // padded corner window and a full one
        write_geometry(2, 1, 1, 2, 2, 3, 3, 16'hC010);
        queue_window(0, 0, 2, 2);
        queue_window(1, 1, 2, 2);
        drain();

        // empty window, zero image height, zero stride, crossed clamp bounds
        write_geometry(0, 15, 15, 0, 31, 8191, 0, 16'h00FF);
        push_tap(128, 4095, 4095, 0, 0, 1'b1);
        drain();

        // oversized filter and image
        write_geometry(31, 0, 0, 31, 31, 8191, 8191, 16'hFFFF);
        push_tap(255, 0, 0, 0, 0, 1'b1);
        push_tap(255, 4095, 0, 0, 0, 1'b1);
        drain();

        // repeated taps wrap the window sum
        write_geometry(1, 0, 0, 16, 16, 4096, 4096, 16'hFF00);
        for (int i = 0; i < 258; i++) begin
            push_tap(255, 0, 0, 0, 0, i == 257);
        end
        drain();

        random_taps = 0;
        phase_no = 0;
        while (random_taps < TAP_TARGET) begin
            randomize_geometry();
            calm = phase_no == 3;
            first = taps_queued;
            phase_len = $urandom_range(50, 90);
            while (taps_queued - first < phase_len) begin
                if ($urandom_range(4) == 0) begin
                    push_tap($urandom_range(255), $urandom_range(4095), $urandom_range(4095),
                             $urandom_range(15), $urandom_range(15), $urandom_range(3) == 0);
                end else begin
                    queue_random_window();
                end
            end
            // close any open window before the next settings
            push_tap(rand_sample(), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(15), $urandom_range(15), 1'b1);
            drain();
            calm = 1'b0;
            random_taps += taps_queued - first;
            phase_no++;
        end

        if (errors == 0 && window_avgs_q.size() == 0) begin
            $display("quantized_average_pool_core test passed");
        end else begin
            $display("quantized_average_pool_core test failed");
        end
        $finish;
    end

endmodule

// ===== quantized_average_pool_core.f =====
hw/rtl/qap_pkg.sv
hw/rtl/qap_front.sv
hw/rtl/qap_queue.sv
hw/rtl/qap_back.sv
hw/rtl/quantized_average_pool_core.sv
bench/tb_top.sv
